### hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text-mode console writer
// Screen geometry, character codes, operation and command types.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;

  localparam int unsigned ADDR_W = $clog2(CELL_COUNT);
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;

  // Field widths
  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CELL_ADDR_W = 11;
  localparam int unsigned CURSOR_W    = 11;
  localparam int unsigned COLOR_W     = 4;
  localparam int unsigned ATTR_W      = 2 * COLOR_W;
  localparam int unsigned CELL_W      = CHAR_W + ATTR_W;
  localparam int unsigned CFG_IDX_W   = 1;

  // Character codes and limits
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] RETURN_CODE  = 8'd13;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
  localparam int unsigned       ERASE_FLOOR  = 4;

  localparam logic [COLOR_W-1:0] RESET_FG = 4'hF;
  localparam logic [COLOR_W-1:0] RESET_BG = 4'h0;
  localparam logic [CELL_W-1:0]  RESET_CELL = {RESET_BG, RESET_FG, BLANK_CODE};

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT   = 2'd0,
    OP_ERASE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG = 1'b0,
    CFG_BG = 1'b1
  } cfg_reg_e;

  // Long-running work the back part performs after the optional cell write
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SCROLL = 2'd1,
    ACT_FILL   = 2'd2,
    ACT_READ   = 2'd3
  } act_e;

  typedef struct packed {
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [CELL_W-1:0]     wr_word;
    act_e                  act;
    logic                  rd_valid;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ATTR_W-1:0]     attr;
    logic [CURSOR_W-1:0]   cursor_position;
    logic                  cursor_updated;
    logic                  scrolled;
  } cmd_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_position;
    logic                cursor_updated;
    logic                scrolled;
    logic [CELL_W-1:0]   cell_data;
  } rsp_t;

endpackage

### hw/rtl/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if: channel interfaces of the text-mode console writer
// Command, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface tcw_cmd_if import tcw_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OPCODE_W-1:0]    opcode;
  logic [CHAR_W-1:0]      char_code;
  logic [CELL_ADDR_W-1:0] cell_address;

  modport source (output valid, opcode, char_code, cell_address, input ready);
  modport sink   (input valid, opcode, char_code, cell_address, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CURSOR_W-1:0] cursor_position;
  logic                cursor_updated;
  logic                scrolled;
  logic [CELL_W-1:0]   cell_data;

  modport source (output valid, cursor_position, cursor_updated, scrolled, cell_data,
                  input ready);
  modport sink   (input valid, cursor_position, cursor_updated, scrolled, cell_data,
                  output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COLOR_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hw/rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: command decode and cursor tracking
// Accepts commands, moves the cursor and emits memory commands.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_cmd_if.sink   cmd_i,
  tcw_cfg_if.sink   cfg_i,
  input  logic      init_done_i,
  input  logic      q_full_i,
  output logic      push_o,
  output cmd_t      push_cmd_o
);

  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [ADDR_W-1:0]  base_q, base_d;   // row_q * COLUMNS, kept incrementally
  logic [COLOR_W-1:0] fg_q, bg_q;
  logic [ATTR_W-1:0]  attr;
  logic [COL_W:0]     col_inc;
  logic               adv;
  cmd_t               cmd_d;

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = init_done_i && !q_full_i;
  assign push_o      = cmd_i.valid && cmd_i.ready;
  assign push_cmd_o  = cmd_d;
  assign attr        = {bg_q, fg_q};
  assign col_inc     = {1'b0, col_q} + (COL_W + 1)'(1);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    base_d = base_q;
    adv    = 1'b0;
    cmd_d          = '0;
    cmd_d.act      = ACT_NONE;
    cmd_d.attr     = attr;
    cmd_d.rd_addr  = ADDR_W'(cmd_i.cell_address);
    case (op_e'(cmd_i.opcode))
      OP_PUT: begin
        cmd_d.cursor_updated = 1'b1;
        if (cmd_i.char_code == NEWLINE_CODE) begin
          col_d = '0;
          adv   = 1'b1;
        end else if (cmd_i.char_code == RETURN_CODE) begin
          col_d = '0;
        end else begin
          cmd_d.wr_en   = 1'b1;
          cmd_d.wr_addr = base_q + ADDR_W'(col_q);
          cmd_d.wr_word = {attr, cmd_i.char_code};
          if (col_inc == (COL_W + 1)'(COLUMNS)) begin
            col_d = '0;
            adv   = 1'b1;
          end else begin
            col_d = col_inc[COL_W-1:0];
          end
        end
        if (adv) begin
          if (row_q == ROW_W'(ROWS - 1)) begin
            col_d          = '0;
            cmd_d.act      = ACT_SCROLL;
            cmd_d.scrolled = 1'b1;
          end else begin
            row_d  = row_q + ROW_W'(1);
            base_d = base_q + ADDR_W'(COLUMNS);
          end
        end
      end
      OP_ERASE: begin
        if (32'(col_q) >= ERASE_FLOOR) begin
          if (col_q != COL_W'(ERASE_FLOOR)) begin
            col_d = col_q - COL_W'(1);
          end
          cmd_d.wr_en          = 1'b1;
          cmd_d.wr_addr        = base_q + ADDR_W'(col_d);
          cmd_d.wr_word        = {attr, BLANK_CODE};
          cmd_d.cursor_updated = 1'b1;
        end
      end
      OP_CLEAR: begin
        col_d  = '0;
        row_d  = '0;
        base_d = '0;
        cmd_d.act            = ACT_FILL;
        cmd_d.cursor_updated = 1'b1;
      end
      OP_READ: begin
        cmd_d.act      = ACT_READ;
        cmd_d.rd_valid = 32'(cmd_i.cell_address) < CELL_COUNT;
      end
      default: ;
    endcase
    cmd_d.cursor_position = CURSOR_W'(base_d + ADDR_W'(col_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      base_q <= '0;
      fg_q   <= RESET_FG;
      bg_q   <= RESET_BG;
    end else begin
      if (push_o) begin
        col_q  <= col_d;
        row_q  <= row_d;
        base_q <= base_d;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_reg_e'(cfg_i.index))
          CFG_FG:  fg_q <= cfg_i.data;
          CFG_BG:  bg_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  a_cursor_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < COLUMNS) && (32'(row_q) < ROWS) &&
    (32'(base_q) == 32'(row_q) * COLUMNS))
    else $error("cursor left the screen or row base out of step");

endmodule

### hw/rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue: command queue between front and back
// Small register FIFO of decoded commands.
// ----------------------------------------------------------------------------
module tcw_queue import tcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("command popped from an empty queue");

endmodule

### hw/rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back: screen memory sequencer
// Executes cell writes, scrolls, fills and reads; holds the response.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  cmd_t      q_head_i,
  output logic      pop_o,
  output logic      init_done_o,
  tcw_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY,
    ST_BLANK,
    ST_FILL,
    ST_READ
  } state_e;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);

  state_e            state_q;
  logic [ADDR_W-1:0] src_q, dst_q;
  logic              rd_pend_q;
  cmd_t              cur_q;
  logic              out_valid_q;
  rsp_t              out_q;
  logic              rsp_set;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;
  logic [CELL_W-1:0] blank;

  assign blank       = {cur_q.attr, BLANK_CODE};
  assign init_done_o = state_q != ST_INIT;
  assign pop_o       = (state_q == ST_IDLE) && !q_empty_i && (!out_valid_q || rsp_o.ready);

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.cursor_position = out_q.cursor_position;
  assign rsp_o.cursor_updated  = out_q.cursor_updated;
  assign rsp_o.scrolled        = out_q.scrolled;
  assign rsp_o.cell_data       = out_q.cell_data;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dst_q;
    ram_wdata = blank;
    ram_re    = 1'b0;
    ram_raddr = src_q;
    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_CELL;
      end
      ST_IDLE: begin
        if (pop_o && q_head_i.wr_en) begin
          ram_we    = 1'b1;
          ram_waddr = q_head_i.wr_addr;
          ram_wdata = q_head_i.wr_word;
        end
        if (pop_o && (q_head_i.act == ACT_READ) && q_head_i.rd_valid) begin
          ram_re    = 1'b1;
          ram_raddr = q_head_i.rd_addr;
        end
      end
      ST_COPY: begin
        // read one row ahead, write the word read last cycle
        ram_re    = 1'b1;
        ram_we    = rd_pend_q;
        ram_wdata = ram_rdata;
      end
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_wdata = rd_pend_q ? ram_rdata : blank;
      end
      ST_FILL: begin
        ram_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Raise the response when a command finishes this cycle
  always_comb begin
    rsp_set = 1'b0;
    case (state_q)
      ST_IDLE: begin
        rsp_set = pop_o && ((q_head_i.act == ACT_NONE) ||
                            ((q_head_i.act == ACT_READ) && !q_head_i.rd_valid));
      end
      ST_BLANK, ST_FILL: begin
        rsp_set = dst_q == LAST_CELL;
      end
      ST_READ: begin
        rsp_set = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      src_q       <= '0;
      dst_q       <= '0;
      rd_pend_q   <= 1'b0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (rsp_set) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT: begin
          if (dst_q == LAST_CELL) begin
            dst_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            dst_q <= dst_q + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (pop_o) begin
            cur_q                 <= q_head_i;
            out_q.cursor_position <= q_head_i.cursor_position;
            out_q.cursor_updated  <= q_head_i.cursor_updated;
            out_q.scrolled        <= q_head_i.scrolled;
            out_q.cell_data       <= '0;
            case (q_head_i.act)
              ACT_NONE: ;
              ACT_SCROLL: begin
                src_q     <= ADDR_W'(COLUMNS);
                dst_q     <= '0;
                rd_pend_q <= 1'b0;
                state_q   <= ST_COPY;
              end
              ACT_FILL: begin
                dst_q   <= '0;
                state_q <= ST_FILL;
              end
              ACT_READ: begin
                if (q_head_i.rd_valid) begin
                  state_q <= ST_READ;
                end
              end
              default: ;
            endcase
          end
        end
        ST_COPY: begin
          src_q     <= src_q + ADDR_W'(1);
          rd_pend_q <= 1'b1;
          if (rd_pend_q) begin
            dst_q <= dst_q + ADDR_W'(1);
          end
          if (src_q == LAST_CELL) begin
            state_q <= ST_BLANK;
          end
        end
        ST_BLANK: begin
          dst_q     <= dst_q + ADDR_W'(1);
          rd_pend_q <= 1'b0;
          if (dst_q == LAST_CELL) begin
            state_q <= ST_IDLE;
          end
        end
        ST_FILL: begin
          dst_q <= dst_q + ADDR_W'(1);
          if (dst_q == LAST_CELL) begin
            state_q <= ST_IDLE;
          end
        end
        ST_READ: begin
          out_q.cell_data <= ram_rdata;
          state_q         <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_busy_no_response: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY || state_q == ST_BLANK || state_q == ST_FILL ||
     state_q == ST_READ) |-> !out_valid_q)
    else $error("response pending while a memory sequence runs");

  a_copy_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> (32'(src_q) == 32'(dst_q) + COLUMNS + 32'(rd_pend_q)))
    else $error("scroll read pointer out of step with write pointer");

  a_no_pop_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> !pop_o)
    else $error("command taken during the clearing pass");

endmodule

### hw/rtl/text_mode_console_writer.sv
// ----------------------------------------------------------------------------
// text_mode_console_writer: text-mode console engine
// Screen of COLUMNS x ROWS character cells with cursor, scroll and clear.
// ----------------------------------------------------------------------------
// Every accepted command returns exactly one response, in order. After reset
// the screen memory is swept to blank white-on-black cells, one cell per
// cycle (COLUMNS*ROWS = 2000 cells); commands are held off during the sweep
// while color writes are taken at once. The front decodes a command in the
// cycle it is accepted and queues a memory command, so the command port takes
// one transfer per cycle until the two-entry queue fills. The back, built
// around one single-port-write, single-port-read screen RAM, sets the rate:
// a put, erase or out-of-screen read finishes in the cycle it leaves the
// queue; a read ends in ST_READ (registered RAM read); a clear blanks
// every cell in ST_FILL; a put that scrolls runs ST_COPY, copying each
// cell below the top row up one row through the RAM, then ST_BLANK for
// the bottom row. A command leaves the queue only when the response
// register is empty or its transfer happens in that same cycle, so a stalled
// response holds the back, and once the queue fills, the command port too.
// ----------------------------------------------------------------------------
module text_mode_console_writer import tcw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_cmd_if.sink   cmd_i,
  tcw_rsp_if.source rsp_o,
  tcw_cfg_if.sink   cfg_i
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic pop;
  cmd_t head;
  logic init_done;

  // Decode commands, track the cursor, hold the color registers
  tcw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .cfg_i       (cfg_i),
    .init_done_i (init_done),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  // Decouple decode from the memory sequencer
  tcw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  // Run writes, scrolls, fills and reads on the screen RAM; drive responses
  tcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head),
    .pop_o       (pop),
    .init_done_o (init_done),
    .rsp_o       (rsp_o)
  );

endmodule
